/* rtl/swmra_pkg.sv */
// Shared types and constants for the sliding-window least-rotation anchor block.
// No dependencies.
package swmra_pkg;

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned WLEN_W   = 7;
  localparam int unsigned TAIL_W   = 6;
  localparam int unsigned OFF_W    = 6;
  localparam int unsigned ANCHOR_W = 32;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_REDUCE_ENABLE = 2'd1,
    REG_REDUCED_TAIL  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic              start;
    logic              reduce;
    logic [TAIL_W-1:0] tail;
  } scan_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scan_stat_t;

endpackage

/* rtl/swmra_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swmra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/swmra_ftab.sv */
// Failure table: RAM plus per-entry valid flops; an invalid entry reads as all ones.
// Depends on swmra_ram.
module swmra_ftab #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [DEPTH-1:0] valid_q;
  logic             valid_rd_q;
  logic [WIDTH-1:0] ram_rdata;

  swmra_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .raddr_i(raddr_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      valid_rd_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      // addresses past the table read as invalid
      valid_rd_q <= (32'(raddr_i) < DEPTH) ? valid_q[raddr_i] : 1'b0;
    end
  end

  assign rdata_o = valid_rd_q ? ram_rdata : '1;

endmodule

/* rtl/swmra_ridx.sv */
// Ring index unit: maps a window offset t (below twice the window length) to a ring address.
// No dependencies.
module swmra_ridx #(
  parameter int unsigned MAX_WINDOW = 64,
  localparam int unsigned NW  = $clog2(MAX_WINDOW + 1),
  localparam int unsigned JW  = $clog2(2 * MAX_WINDOW + 1),
  localparam int unsigned RAW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic [JW-1:0]  t_i,
  input  logic [NW-1:0]  n_i,
  input  logic [RAW-1:0] head_i,
  output logic [RAW-1:0] addr_o
);

  localparam int unsigned SW = $clog2(2 * MAX_WINDOW + 1) + 1;

  logic [JW-1:0] t_mod;
  logic [SW-1:0] sum;

  always_comb begin
    t_mod = (t_i >= JW'(n_i)) ? (t_i - JW'(n_i)) : t_i;
    // head - n + (t mod n), kept non-negative by adding the ring depth
    sum = SW'(head_i) + SW'(t_mod) + SW'(MAX_WINDOW) - SW'(n_i);
    if (sum >= SW'(MAX_WINDOW)) begin
      sum = sum - SW'(MAX_WINDOW);
    end
    addr_o = RAW'(sum);
  end

endmodule

/* rtl/swmra_scan.sv */
// Booth least-rotation scan sequencer over the window ring and failure table.
// Depends on swmra_pkg, swmra_ftab, swmra_ridx.
module swmra_scan #(
  parameter int unsigned MAX_WINDOW = 64,
  localparam int unsigned NW  = $clog2(MAX_WINDOW + 1),
  localparam int unsigned JW  = $clog2(2 * MAX_WINDOW + 1),
  localparam int unsigned RAW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swmra_pkg::scan_ctrl_t  ctrl_i,
  input  logic [NW-1:0]          n_i,
  input  logic [RAW-1:0]         head_i,
  output logic [RAW-1:0]         ring_raddr_o,
  input  logic [swmra_pkg::SYM_W-1:0] ring_rdata_i,
  input  logic                   res_take_i,
  output swmra_pkg::scan_stat_t  stat_o,
  output logic [JW-1:0]          k_o
);
  import swmra_pkg::*;

  localparam int unsigned FT_DEPTH = 2 * MAX_WINDOW;
  localparam int unsigned FAW = $clog2(FT_DEPTH);
  localparam int unsigned FW  = $clog2(FT_DEPTH) + 1;
  localparam int unsigned CW  = ((JW > TAIL_W) ? JW : TAIL_W) + 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_SJ,
    ST_GET_SJ,
    ST_CHK,
    ST_CMP,
    ST_NEXT,
    ST_TAIL,
    ST_WR,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [JW-1:0]    j_q;
  logic [JW-1:0]    k_q;
  logic [FW-1:0]    i_q;
  logic [FW-1:0]    wval_q;
  logic [SYM_W-1:0] sj_q;

  logic             i_none;
  logic [JW-1:0]    t_sel;
  logic [JW-1:0]    jm;
  logic [JW-1:0]    nd;
  logic             ok_cmp;
  logic             ok_tail;
  logic [FAW-1:0]   ft_raddr;
  logic [FAW-1:0]   ft_waddr;
  logic [FW-1:0]    ft_rdata;
  logic             ft_we;
  logic             ft_clr;

  always_comb begin
    i_none   = &i_q;
    jm       = j_q - JW'(i_q[FAW-1:0]) - JW'(1);
    nd       = JW'({n_i, 1'b0});
    ok_cmp   = !ctrl_i.reduce || ((CW'(jm) + CW'(ctrl_i.tail)) < CW'(n_i));
    ok_tail  = !ctrl_i.reduce || ((CW'(j_q) + CW'(ctrl_i.tail)) < CW'(n_i));
    if (state_q == ST_RD_SJ) begin
      t_sel    = j_q;
      ft_raddr = FAW'(j_q - k_q - JW'(1));
    end else begin
      t_sel    = i_none ? k_q : (k_q + JW'(i_q[FAW-1:0]) + JW'(1));
      ft_raddr = i_q[FAW-1:0];
    end
    ft_waddr = FAW'(j_q - k_q);
    ft_we    = (state_q == ST_WR);
    ft_clr   = (state_q == ST_IDLE) && ctrl_i.start;
  end

  swmra_ridx #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_ridx (
    .t_i   (t_sel),
    .n_i   (n_i),
    .head_i(head_i),
    .addr_o(ring_raddr_o)
  );

  swmra_ftab #(
    .DEPTH(FT_DEPTH),
    .WIDTH(FW)
  ) u_ftab (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (ft_clr),
    .we_i   (ft_we),
    .waddr_i(ft_waddr),
    .wdata_i(wval_q),
    .raddr_i(ft_raddr),
    .rdata_o(ft_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q     <= '0;
      k_q     <= '0;
      i_q     <= '1;
      wval_q  <= '1;
      sj_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (ctrl_i.start) begin
            j_q     <= JW'(1);
            k_q     <= '0;
            state_q <= ST_RD_SJ;
          end
        end
        ST_RD_SJ: begin
          state_q <= ST_GET_SJ;
        end
        ST_GET_SJ: begin
          sj_q    <= ring_rdata_i;
          i_q     <= ft_rdata;
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          state_q <= i_none ? ST_TAIL : ST_CMP;
        end
        ST_CMP: begin
          if (sj_q != ring_rdata_i) begin
            if ((sj_q < ring_rdata_i) && ok_cmp) begin
              k_q <= jm;
            end
            state_q <= ST_NEXT;
          end else begin
            wval_q  <= i_q + FW'(1);
            state_q <= ST_WR;
          end
        end
        ST_NEXT: begin
          i_q     <= ft_rdata;
          state_q <= ST_CHK;
        end
        ST_TAIL: begin
          if (sj_q != ring_rdata_i) begin
            if ((sj_q < ring_rdata_i) && ok_tail) begin
              k_q <= j_q;
            end
            wval_q <= '1;
          end else begin
            wval_q <= '0;
          end
          state_q <= ST_WR;
        end
        ST_WR: begin
          j_q <= j_q + JW'(1);
          if ((j_q + JW'(1)) >= nd) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_RD_SJ;
          end
        end
        ST_DONE: begin
          if (res_take_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);
  assign k_o         = k_q;

endmodule

/* rtl/sliding_window_min_rotation_anchor.sv */
// Sliding-window least-rotation anchor: top level with ring, counters and result register.
// Depends on swmra_pkg, swmra_ram, swmra_scan.
// A byte that completes a window starts a scan over the 2n-1 offsets of the doubled window (n the
//   window length), walking the failure chain; out_valid_o rises once the result register takes k.
//   Such a byte holds the input off until that take, which waits while the result register is
//   stalled; other bytes are taken every cycle. Reset clears counters and sets config to defaults.
module sliding_window_min_rotation_anchor #(
  parameter int unsigned MAX_WINDOW    = 64,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [swmra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [swmra_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [swmra_pkg::SYM_W-1:0]      symbol_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [swmra_pkg::ANCHOR_W-1:0]   anchor_position_o,
  output logic [swmra_pkg::OFF_W-1:0]      rotation_offset_o
);
  import swmra_pkg::*;

  localparam int unsigned NW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned JW  = $clog2(2 * MAX_WINDOW + 1);
  localparam int unsigned RAW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned PW  = POSITION_BITS;

  logic [WLEN_W-1:0]   wlen_q;
  logic                reduce_q;
  logic [TAIL_W-1:0]   tail_q;
  logic [RAW-1:0]      head_q;
  logic [NW-1:0]       fill_q;
  logic [PW-1:0]       pos_q;
  logic                start_q;
  logic                out_valid_q;
  logic [PW-1:0]       base_q;
  logic [ANCHOR_W-1:0] anchor_q;
  logic [OFF_W-1:0]    offset_q;

  logic [NW-1:0]       n_eff;
  logic [NW-1:0]       fill_d;
  logic                accept;
  logic                take;
  logic [RAW-1:0]      ring_raddr;
  logic [SYM_W-1:0]    ring_rdata;
  logic [JW-1:0]       k;
  scan_ctrl_t          ctrl;
  scan_stat_t          stat;

  always_comb begin
    if (wlen_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(wlen_q) > 32'(MAX_WINDOW)) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(wlen_q);
    end
    fill_d = (32'(fill_q) < 32'(MAX_WINDOW)) ? (fill_q + NW'(1)) : fill_q;
  end

  assign in_stall_o  = start_q | stat.busy;
  assign accept      = in_valid_i & ~in_stall_o;
  assign take        = stat.done & (~out_valid_q | ~out_stall_i);

  assign ctrl.start  = start_q;
  assign ctrl.reduce = reduce_q;
  assign ctrl.tail   = tail_q;

  swmra_ram #(
    .WIDTH(SYM_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(head_q),
    .wdata_i(symbol_i),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  swmra_scan #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .n_i         (n_eff),
    .head_i      (head_q),
    .ring_raddr_o(ring_raddr),
    .ring_rdata_i(ring_rdata),
    .res_take_i  (take),
    .stat_o      (stat),
    .k_o         (k)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q      <= WLEN_RESET;
      reduce_q    <= 1'b0;
      tail_q      <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_WINDOW_LENGTH: wlen_q   <= cfg_data_i[WLEN_W-1:0];
          REG_REDUCE_ENABLE: reduce_q <= cfg_data_i[0];
          REG_REDUCED_TAIL:  tail_q   <= cfg_data_i[TAIL_W-1:0];
          default: begin
          end
        endcase
      end
      start_q <= accept && (fill_d >= n_eff);
      if (accept) begin
        head_q <= (32'(head_q) == MAX_WINDOW - 1) ? '0 : (head_q + RAW'(1));
        fill_q <= fill_d;
        pos_q  <= pos_q + PW'(1);
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window start is sampled once the position has moved past the new byte
  always_ff @(posedge clk_i) begin
    if (start_q) begin
      base_q <= pos_q - PW'(n_eff);
    end
    if (take) begin
      anchor_q <= ANCHOR_W'(base_q + PW'(k));
      offset_q <= OFF_W'(k);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign anchor_position_o = anchor_q;
  assign rotation_offset_o = offset_q;

endmodule
